### rtl/qsr_pkg.sv
// ----------------------------------------------------------------------------
// qsr_pkg
// shared widths, mode codes, register indexes and the configuration struct
// ----------------------------------------------------------------------------
`default_nettype none

package qsr_pkg;

	localparam int CHAR_W  = 8;
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 2;
	localparam int SCORE_W = CHAR_W + 2;

	typedef logic [MODE_W-1:0]  mode_t;
	typedef logic [INDEX_W-1:0] cfg_index_t;

	localparam mode_t MODE_PLAIN   = 2'd0;
	localparam mode_t MODE_LOGODDS = 2'd1;
	localparam mode_t MODE_OLDER   = 2'd2;

	localparam cfg_index_t CFG_INPUT_MODE      = 2'd0;
	localparam cfg_index_t CFG_OUTPUT_MODE     = 2'd1;
	localparam cfg_index_t CFG_ENCODING_OFFSET = 2'd2;
	localparam cfg_index_t CFG_MAX_SCORE       = 2'd3;

	localparam logic [CHAR_W-1:0] RESET_OFFSET    = 8'd64;
	localparam logic [CHAR_W-1:0] RESET_MAX_SCORE = 8'd62;

	typedef struct packed {
		mode_t             input_mode;
		mode_t             output_mode;
		logic [CHAR_W-1:0] encoding_offset;
		logic [CHAR_W-1:0] max_score;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/qsr_remap.sv
// ----------------------------------------------------------------------------
// qsr_remap
// if modes differ, decodes a quality char to a phred score, clamps, re-encodes
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_remap
	import qsr_pkg::*;
(
	input  cfg_t              cfg,
	input  logic [CHAR_W-1:0] quality_char,
	output logic [CHAR_W-1:0] converted_char
);

	logic signed [SCORE_W-1:0] q;
	logic signed [SCORE_W-1:0] score;
	logic signed [SCORE_W-1:0] clamped;
	logic signed [SCORE_W-1:0] enc;
	logic signed [SCORE_W-1:0] max_ext;
	logic        [CHAR_W-1:0]  coded;

	assign q       = $signed({2'b00, quality_char}) - $signed({2'b00, cfg.encoding_offset});
	assign max_ext = $signed({2'b00, cfg.max_score});

	// decode
	always_comb begin
		score = q;
		case (cfg.input_mode)
			MODE_LOGODDS: begin
				if (q < 10'sd2)       score = 10'sd1;
				else if (q < 10'sd4)  score = 10'sd2;
				else if (q < 10'sd6)  score = 10'sd3;
				else if (q < 10'sd8)  score = 10'sd4;
				else if (q < 10'sd11) score = 10'sd5;
				else if (q < 10'sd14) score = q - 10'sd4;
				else if (q < 10'sd16) score = 10'sd10;
				else                  score = q - 10'sd5;
			end
			MODE_OLDER: begin
				if (q == 10'sd2) score = 10'sd0;
			end
			default: score = q;
		endcase
	end

	assign clamped = (score > max_ext) ? max_ext : score;

	// encode
	always_comb begin
		enc = clamped;
		case (cfg.output_mode)
			MODE_OLDER: begin
				if (clamped < 10'sd3) enc = 10'sd3;
			end
			MODE_LOGODDS: begin
				if (clamped > 10'sd6)       enc = clamped + 10'sd4;
				else if (clamped > 10'sd3)  enc = clamped + 10'sd3;
				else if (clamped == 10'sd3) enc = 10'sd5;
				else if (clamped == 10'sd2) enc = 10'sd3;
				else if (clamped >= 10'sd0) enc = 10'sd0;
				else                        enc = 10'sd5;
			end
			default: enc = clamped;
		endcase
	end

	assign coded = enc[CHAR_W-1:0] + cfg.encoding_offset;

	assign converted_char = (cfg.input_mode == cfg.output_mode) ? quality_char : coded;

endmodule

`default_nettype wire

### rtl/quality_score_remapper_unit.sv
// ----------------------------------------------------------------------------
// quality_score_remapper_unit
// quality character scale converter with register-mapped mode selection
// ----------------------------------------------------------------------------
// each accepted item passes the input register, then the result register
// throughput: one item per cycle, set by the input and result registers
// busy stays low; done marks each result for one cycle
// reset: modes plain, offset 64, max score 62, no result pending
`default_nettype none

module quality_score_remapper_unit
	import qsr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CHAR_W-1:0]  quality_char,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]  cfg_data,
	output logic               done,
	output logic [CHAR_W-1:0]  converted_char
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              valid_s2;
	logic [CHAR_W-1:0] char_s2;
	logic [CHAR_W-1:0] remap_char;
	logic              accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_mode      <= MODE_PLAIN;
			cfg_q.output_mode     <= MODE_PLAIN;
			cfg_q.encoding_offset <= RESET_OFFSET;
			cfg_q.max_score       <= RESET_MAX_SCORE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INPUT_MODE:      cfg_q.input_mode      <= cfg_data[MODE_W-1:0];
				CFG_OUTPUT_MODE:     cfg_q.output_mode     <= cfg_data[MODE_W-1:0];
				CFG_ENCODING_OFFSET: cfg_q.encoding_offset <= cfg_data;
				CFG_MAX_SCORE:       cfg_q.max_score       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) char_s1 <= quality_char;
		if (valid_s1) char_s2 <= remap_char;
	end

	qsr_remap u_remap (
		.cfg            (cfg_q),
		.quality_char   (char_s1),
		.converted_char (remap_char)
	);

	assign done           = valid_s2;
	assign converted_char = char_s2;

endmodule

`default_nettype wire

### rtl/qsr_checker.sv
// ----------------------------------------------------------------------------
// qsr_checker
// port-level timing checks for the quality score remapper, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_checker
	import qsr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [CHAR_W-1:0] quality_char,
	input logic              done,
	input logic [CHAR_W-1:0] converted_char
);

	// every accepted item yields a result on done
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted item produced no result");

	// no result on done without an earlier accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	// same item twice in a row under unchanged config gives the same result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && $past(arst_n) && $past(start && !busy)
			&& quality_char == $past(quality_char) && !(cfg_valid && cfg_ready))
		|=> ##1 (converted_char == $past(converted_char)))
		else $error("repeated item changed result");

endmodule

bind quality_score_remapper_unit qsr_checker u_qsr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready),
	.quality_char   (quality_char),
	.done           (done),
	.converted_char (converted_char)
);

`default_nettype wire
